FILE: src/ppwm_pkg.sv
// types and constants for the proportional pressure pwm controller
// used by the output channel interface and by the top level
`timescale 1ns / 1ps

package ppwm_pkg;

  localparam int unsigned PeriodW = 8;
  localparam int unsigned LevelW  = 12;
  localparam int unsigned OffsetW = 25;
  localparam int unsigned SlopeW  = 26;
  localparam int unsigned DacW    = 16;
  localparam int unsigned FracW   = 24;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [PeriodW-1:0] PeriodReset = 8'd40;
  localparam logic [LevelW-1:0]  OnLevelReset = 12'd3999;
  localparam logic [OffsetW-1:0] OffsetReset = 25'd4278190;
  localparam logic [SlopeW-1:0]  SlopeReset = 26'd4100;

  localparam logic [DacW-LevelW-1:0] DacCmd = 4'h3;

  typedef enum logic [1:0] {
    REG_PERIOD   = 2'd0,
    REG_ON_LEVEL = 2'd1,
    REG_OFFSET   = 2'd2,
    REG_SLOPE    = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ERR,
    ST_MUL_PER,
    ST_ROUND,
    ST_FINISH
  } ctrl_state_e;

endpackage

FILE: src/ppwm_if.sv
// valid/ready channel interfaces for the sample and result words
// depends on ppwm_pkg for field widths
`timescale 1ns / 1ps

interface ppwm_in_if #(
  parameter int unsigned SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] desired_sample;
  logic [SAMPLE_BITS-1:0] actual_sample;

  modport source (output valid, desired_sample, actual_sample, input ready);
  modport sink (input valid, desired_sample, actual_sample, output ready);
endinterface

interface ppwm_out_if
  import ppwm_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [DacW-1:0]      dac_word;
  logic                 drive_on;
  logic [PeriodW-1:0]   switch_point;

  modport source (output valid, dac_word, drive_on, switch_point, input ready);
  modport sink (input valid, dac_word, drive_on, switch_point, output ready);
endinterface

FILE: src/proportional_pressure_pwm_controller.sv
// proportional pressure controller with pwm dac output, bit-serial multiplies
// depends on ppwm_pkg and the channel interfaces in ppwm_if
//
//   channel  | dir | handshake    | word
//   in_i     | in  | valid/ready  | desired_sample, actual_sample
//   out_o    | out | valid/ready  | dac_word, drive_on, switch_point
//   apb      | in  | psel/penable | period, on_level, duty_offset, duty_slope
//
// one word steps through: accept, the serial slope-by-error multiply, the serial
// duty-by-period multiply, round, then clamp and update the pwm state; both
// multiplies share one shift-add accumulator. a new word is taken only in idle;
// the result sits in an output register, so a stalled sink holds the finish step
// until the register frees.
// reset clears the control state and loads the register reset values.
`timescale 1ns / 1ps

module proportional_pressure_pwm_controller
  import ppwm_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ppwm_in_if.sink             in_i,
  ppwm_out_if.source          out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned ErrW = SAMPLE_BITS + 1;
  localparam int unsigned DutyW = SlopeW + ErrW + 1;
  localparam int unsigned ProdW = DutyW + PeriodW;
  localparam int unsigned UpW = ProdW - FracW;
  localparam int unsigned CntW = $clog2(ErrW + 1);
  localparam logic [ProdW-1:0] RoundBit = ProdW'(1) << (FracW - 1);

  // configuration registers
  logic [PeriodW-1:0] period_q;
  logic [LevelW-1:0]  on_level_q;
  logic [OffsetW-1:0] offset_q;
  logic [SlopeW-1:0]  slope_q;
  reg_idx_e           reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PeriodReset;
      on_level_q <= OnLevelReset;
      offset_q   <= OffsetReset;
      slope_q    <= SlopeReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PERIOD:   period_q   <= pwdata[PeriodW-1:0];
        REG_ON_LEVEL: on_level_q <= pwdata[LevelW-1:0];
        REG_OFFSET:   offset_q   <= pwdata[OffsetW-1:0];
        REG_SLOPE:    slope_q    <= pwdata[SlopeW-1:0];
        default:      period_q   <= period_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD:   prdata = ApbDataW'(period_q);
      REG_ON_LEVEL: prdata = ApbDataW'(on_level_q);
      REG_OFFSET:   prdata = ApbDataW'(offset_q);
      REG_SLOPE:    prdata = {{(ApbDataW-SlopeW){slope_q[SlopeW-1]}}, slope_q};
      default:      prdata = '0;
    endcase
  end

  // datapath and control
  ctrl_state_e state_q, state_d;
  logic [ProdW-1:0]   acc_q, acc_d;
  logic [ProdW-1:0]   mcand_q, mcand_d;
  logic [ErrW-1:0]    err_q, err_d;
  logic [PeriodW-1:0] per_q, per_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               pos_q, pos_d;

  // pwm state
  logic [PeriodW-1:0] tick_q, tick_d;
  logic               on_q, on_d;
  logic [LevelW-1:0]  level_q, level_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [DacW-1:0]    dac_q, dac_d;
  logic               drive_q, drive_d;
  logic [PeriodW-1:0] switch_q, switch_d;

  logic [ProdW-1:0]   addend;
  logic [UpW-1:0]     upper;
  logic [PeriodW-1:0] thr;
  logic               out_free;
  logic               load_out;

  assign upper    = acc_q[ProdW-1:FracW];
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    if (!pos_q) begin
      thr = '0;
    end else if ((|upper[UpW-1:PeriodW]) || (upper[PeriodW-1:0] > period_q)) begin
      thr = period_q;
    end else begin
      thr = upper[PeriodW-1:0];
    end
  end

  always_comb begin
    state_d   = state_q;
    acc_d     = acc_q;
    mcand_d   = mcand_q;
    err_d     = err_q;
    per_d     = per_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    tick_d    = tick_q;
    on_d      = on_q;
    level_d   = level_q;
    load_out  = 1'b0;
    in_i.ready = 1'b0;
    addend    = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          err_d   = {1'b0, in_i.desired_sample} - {1'b0, in_i.actual_sample};
          acc_d   = ProdW'(offset_q);
          mcand_d = {{(ProdW-SlopeW){slope_q[SlopeW-1]}}, slope_q};
          cnt_d   = CntW'(ErrW - 1);
          state_d = ST_MUL_ERR;
        end
      end
      ST_MUL_ERR: begin
        addend = err_q[0] ? mcand_q : '0;
        // top error bit carries negative weight
        if (cnt_q == '0) begin
          mcand_d = acc_q - addend;
          acc_d   = '0;
          per_d   = period_q;
          cnt_d   = CntW'(PeriodW - 1);
          state_d = ST_MUL_PER;
        end else begin
          acc_d   = acc_q + addend;
          mcand_d = mcand_q << 1;
          err_d   = err_q >> 1;
          cnt_d   = cnt_q - 1'b1;
        end
      end
      ST_MUL_PER: begin
        addend  = per_q[0] ? mcand_q : '0;
        acc_d   = acc_q + addend;
        mcand_d = mcand_q << 1;
        per_d   = per_q >> 1;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        pos_d   = !acc_q[ProdW-1] && (|acc_q);
        acc_d   = acc_q + RoundBit;
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          load_out = 1'b1;
          if (tick_q >= period_q) begin
            tick_d  = PeriodW'(1);
            level_d = on_level_q;
            on_d    = 1'b1;
          end else begin
            tick_d = tick_q + 1'b1;
            if (on_q && (tick_q >= thr)) begin
              level_d = '0;
              on_d    = 1'b0;
            end
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    dac_d       = dac_q;
    drive_d     = drive_q;
    switch_d    = switch_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      dac_d       = {DacCmd, level_d};
      drive_d     = on_d;
      switch_d    = thr;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      on_q        <= 1'b1;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      on_q        <= on_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    err_q    <= err_d;
    per_q    <= per_d;
    cnt_q    <= cnt_d;
    pos_q    <= pos_d;
    dac_q    <= dac_d;
    drive_q  <= drive_d;
    switch_q <= switch_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.dac_word     = dac_q;
  assign out_o.drive_on     = drive_q;
  assign out_o.switch_point = switch_q;

endmodule
